// ===== src/ede_pkg.sv =====
// edit distance engine: shared constants, action codes and the command struct
// used between the controller and the datapath; depends on nothing
package ede_pkg;

    localparam int MAX_LEN  = 64;
    localparam int LEN_W    = $clog2(MAX_LEN + 1);
    localparam int ADDR_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int ROW_DEPTH = MAX_LEN + 1;
    localparam int DIST_W   = 7;
    localparam int DIST_MAX = (1 << DIST_W) - 1;
    localparam int BYTE_W   = 8;
    localparam int ACT_W    = 2;

    localparam logic [ACT_W-1:0] ACT_FIRST   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SECOND  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

    typedef struct packed {
        logic              wr_first;
        logic              wr_second;
        logic [ADDR_W-1:0] str_wr_addr;
        logic [BYTE_W-1:0] wr_byte;
        logic              rd_first;
        logic [ADDR_W-1:0] first_rd_addr;
        logic              rd_second;
        logic [ADDR_W-1:0] second_rd_addr;
        logic              row_rd;
        logic [LEN_W-1:0]  row_rd_addr;
        logic              row_wr;
        logic              row_wr_cell;
        logic [LEN_W-1:0]  row_wr_addr;
        logic [LEN_W-1:0]  row_wr_val;
        logic              start_row;
        logic              step_cell;
        logic              load_result;
        logic              result_ovf;
    } t_dp_cmd;

endpackage

// ===== src/ede_if.sv =====
// edit distance engine: valid/ready channel interfaces for input and result
// transactions; depends on ede_pkg
interface ede_in_if import ede_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [BYTE_W-1:0] char_byte;

    modport source (output valid, output action, output char_byte, input ready);
    modport sink (input valid, input action, input char_byte, output ready);
endinterface

interface ede_out_if import ede_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;
    logic              overflow;

    modport source (output valid, output distance, output overflow, input ready);
    modport sink (input valid, input distance, input overflow, output ready);
endinterface

// ===== src/ede_datapath.sv =====
// edit distance engine datapath: string memories, row buffer, cell update
// and result register; depends on ede_pkg
module ede_datapath
    import ede_pkg::*;
(
    input  logic              i_clk,
    input  t_dp_cmd           i_cmd,
    output logic [DIST_W-1:0] o_distance,
    output logic              o_overflow
);

    logic [BYTE_W-1:0] r_first_mem  [MAX_LEN];
    logic [BYTE_W-1:0] r_second_mem [MAX_LEN];
    logic [LEN_W-1:0]  r_row_mem    [ROW_DEPTH];

    logic [BYTE_W-1:0] r_first_rd;
    logic [BYTE_W-1:0] r_second_rd;
    logic [LEN_W-1:0]  r_row_rd;
    logic [BYTE_W-1:0] r_b2;
    logic [LEN_W-1:0]  r_diag;
    logic [LEN_W-1:0]  r_left;
    logic [DIST_W-1:0] r_distance;
    logic              r_overflow;

    logic [LEN_W:0]    n_up;
    logic [LEN_W:0]    n_lf;
    logic [LEN_W:0]    n_dg;
    logic [LEN_W:0]    n_m;
    logic [LEN_W-1:0]  n_cell;
    logic [LEN_W-1:0]  n_row_wdata;
    logic [DIST_W-1:0] n_dist;

    // cell update: min of above+1, left+1, diag+mismatch
    always_comb begin
        n_up = {1'b0, r_row_rd} + 1'b1;
        n_lf = {1'b0, r_left} + 1'b1;
        n_dg = {1'b0, r_diag} + ((r_first_rd != r_b2) ? 1'b1 : 1'b0);
        n_m  = (n_up < n_lf) ? n_up : n_lf;
        n_m  = (n_m < n_dg) ? n_m : n_dg;
        n_cell = n_m[LEN_W-1:0];
        n_row_wdata = i_cmd.row_wr_cell ? n_cell : i_cmd.row_wr_val;
        if (int'(r_row_rd) > DIST_MAX) begin
            n_dist = DIST_W'(DIST_MAX);
        end else begin
            n_dist = DIST_W'(r_row_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_first) begin
            r_first_mem[i_cmd.str_wr_addr] <= i_cmd.wr_byte;
        end
        if (i_cmd.wr_second) begin
            r_second_mem[i_cmd.str_wr_addr] <= i_cmd.wr_byte;
        end
        if (i_cmd.rd_first) begin
            r_first_rd <= r_first_mem[i_cmd.first_rd_addr];
        end
        if (i_cmd.rd_second) begin
            r_second_rd <= r_second_mem[i_cmd.second_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_wr) begin
            r_row_mem[i_cmd.row_wr_addr] <= n_row_wdata;
        end
        if (i_cmd.row_rd) begin
            r_row_rd <= r_row_mem[i_cmd.row_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_row) begin
            r_b2   <= r_second_rd;
            r_diag <= r_row_rd;
            r_left <= i_cmd.row_wr_val;
        end else if (i_cmd.step_cell) begin
            r_diag <= r_row_rd;
            r_left <= n_cell;
        end
        if (i_cmd.load_result) begin
            r_distance <= n_dist;
            r_overflow <= i_cmd.result_ovf;
        end
    end

    assign o_distance = r_distance;
    assign o_overflow = r_overflow;

endmodule

// ===== src/ede_ctrl.sv =====
// edit distance engine controller: string lengths, overflow flag, row and
// column counters and result handshake; depends on ede_pkg and ede_if
module ede_ctrl
    import ede_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    ede_in_if.sink  i_in,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_ROW,
        S_ROW2,
        S_CELL_RD,
        S_CELL_WR,
        S_FIN_RD,
        S_FIN
    } t_state;

    t_state           r_state;
    logic [LEN_W-1:0] r_len1;
    logic [LEN_W-1:0] r_len2;
    logic             r_trunc;
    logic [LEN_W-1:0] r_n1;
    logic [LEN_W-1:0] r_n2;
    logic             r_ovf;
    logic [LEN_W-1:0] r_i;
    logic [LEN_W-1:0] r_j;
    logic             r_out_valid;

    logic             n_acc;
    logic             n_len1_ok;
    logic             n_len2_ok;
    logic             n_out_free;
    logic [LEN_W-1:0] n_im1;
    logic [LEN_W-1:0] n_jm1;

    assign n_acc      = i_in.valid && i_in.ready;
    assign n_len1_ok  = int'(r_len1) < MAX_LEN;
    assign n_len2_ok  = int'(r_len2) < MAX_LEN;
    assign n_out_free = !r_out_valid || i_out_ready;
    assign n_im1      = r_i - 1'b1;
    assign n_jm1      = r_j - 1'b1;

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd = '0;
        o_cmd.str_wr_addr    = r_len1[ADDR_W-1:0];
        o_cmd.wr_byte        = i_in.char_byte;
        o_cmd.first_rd_addr  = n_jm1[ADDR_W-1:0];
        o_cmd.second_rd_addr = n_im1[ADDR_W-1:0];
        o_cmd.row_rd_addr    = r_j;
        o_cmd.row_wr_addr    = r_j;
        o_cmd.row_wr_val     = r_j;
        o_cmd.result_ovf     = r_ovf;
        case (r_state)
            S_IDLE: begin
                if (n_acc && i_in.action == ACT_FIRST) begin
                    o_cmd.wr_first = n_len1_ok;
                end
                if (n_acc && i_in.action == ACT_SECOND) begin
                    o_cmd.wr_second   = n_len2_ok;
                    o_cmd.str_wr_addr = r_len2[ADDR_W-1:0];
                end
            end
            S_INIT: begin
                o_cmd.row_wr = 1'b1;
            end
            S_ROW: begin
                o_cmd.row_rd      = 1'b1;
                o_cmd.row_rd_addr = '0;
                o_cmd.rd_second   = 1'b1;
            end
            S_ROW2: begin
                o_cmd.start_row   = 1'b1;
                o_cmd.row_wr      = 1'b1;
                o_cmd.row_wr_addr = '0;
                o_cmd.row_wr_val  = r_i;
            end
            S_CELL_RD: begin
                o_cmd.row_rd   = 1'b1;
                o_cmd.rd_first = 1'b1;
            end
            S_CELL_WR: begin
                o_cmd.row_wr      = 1'b1;
                o_cmd.row_wr_cell = 1'b1;
                o_cmd.step_cell   = 1'b1;
            end
            S_FIN_RD: begin
                o_cmd.row_rd      = 1'b1;
                o_cmd.row_rd_addr = r_n1;
            end
            S_FIN: begin
                o_cmd.load_result = n_out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len1      <= '0;
            r_len2      <= '0;
            r_trunc     <= 1'b0;
            r_n1        <= '0;
            r_n2        <= '0;
            r_ovf       <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_FIN && n_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_acc) begin
                        case (i_in.action)
                            ACT_FIRST: begin
                                if (n_len1_ok) begin
                                    r_len1 <= r_len1 + 1'b1;
                                end else begin
                                    r_trunc <= 1'b1;
                                end
                            end
                            ACT_SECOND: begin
                                if (n_len2_ok) begin
                                    r_len2 <= r_len2 + 1'b1;
                                end else begin
                                    r_trunc <= 1'b1;
                                end
                            end
                            ACT_COMPUTE: begin
                                r_n1    <= r_len1;
                                r_n2    <= r_len2;
                                r_ovf   <= r_trunc;
                                r_len1  <= '0;
                                r_len2  <= '0;
                                r_trunc <= 1'b0;
                                r_j     <= '0;
                                r_state <= S_INIT;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_INIT: begin
                    if (r_j == r_n1) begin
                        r_i <= LEN_W'(1);
                        r_state <= (r_n2 == '0) ? S_FIN_RD : S_ROW;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_ROW: begin
                    r_state <= S_ROW2;
                end
                S_ROW2: begin
                    r_j <= LEN_W'(1);
                    if (r_n1 != '0) begin
                        r_state <= S_CELL_RD;
                    end else if (r_i == r_n2) begin
                        r_state <= S_FIN_RD;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_ROW;
                    end
                end
                S_CELL_RD: begin
                    r_state <= S_CELL_WR;
                end
                S_CELL_WR: begin
                    if (r_j != r_n1) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_CELL_RD;
                    end else if (r_i == r_n2) begin
                        r_state <= S_FIN_RD;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_ROW;
                    end
                end
                S_FIN_RD: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (n_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_len1) <= MAX_LEN) && (int'(r_len2) <= MAX_LEN))
        else $error("string length beyond limit");

    a_compute_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_acc && i_in.action == ACT_COMPUTE)
        |=> (r_len1 == '0 && r_len2 == '0 && !r_trunc))
        else $error("compute did not clear strings");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result raised outside finish");

    a_cell_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CELL_RD)
        |-> (r_j != '0 && r_j <= r_n1 && r_i != '0 && r_i <= r_n2))
        else $error("cell index out of range");

endmodule

// ===== src/edit_distance_engine_core.sv =====
// Levenshtein edit distance engine, top level: joins controller and datapath
// to the input and result channels; depends on ede_pkg, ede_if, ede_ctrl, ede_datapath
//
// Append transactions (action 0 or 1) are accepted whenever the engine is
// idle, even while a finished result waits on the output. A compute transaction
// (action 2) holds the input off until its result is loaded, longer while an
// earlier result still waits on the output; the row buffer is read in one
// state and written in the next for each cell of the distance matrix. Bytes
// beyond 64 per string are dropped and reported through the overflow bit.
// Action 3 is accepted and ignored.
module edit_distance_engine_core
    import ede_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    ede_in_if.sink    i_in,
    ede_out_if.source o_out
);

    t_dp_cmd           cmd;
    logic [DIST_W-1:0] dp_distance;
    logic              dp_overflow;
    logic              out_valid;

    ede_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    ede_datapath u_datapath (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .o_distance (dp_distance),
        .o_overflow (dp_overflow)
    );

    assign o_out.valid    = out_valid;
    assign o_out.distance = dp_distance;
    assign o_out.overflow = dp_overflow;

endmodule
